>>> rtl/core/nrch_pkg.sv
// Shared types and constants for the nearest ray/circle hit block.
// Used by nrch_front, nrch_back and the top level; depends on nothing.
`default_nettype none
package nrch_pkg;

   localparam int unsigned IdWidth       = 16;
   localparam int unsigned CoordWidth    = 20;
   localparam int unsigned DeltaWidth    = CoordWidth + 1;
   localparam int unsigned DirWidth      = 16;
   localparam int unsigned LenWidth      = 16;
   localparam logic [15:0] RayLengthRst  = 16'd25600;
   localparam logic [0:0]  RegRayLength  = 1'b0;

   typedef logic signed [DeltaWidth-1:0] delta_type;

   // One classified object as it waits between the front and back parts.
   typedef struct packed {
      delta_type                   dx;
      delta_type                   dy;
      logic signed [DirWidth-1:0]  ux;
      logic signed [DirWidth-1:0]  uy;
      logic [LenWidth-1:0]         rad;
      logic                        use_obj;
      logic                        last;
   } q_item_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_SQR,
      BK_RANGE,
      BK_PROJ,
      BK_SUM,
      BK_PSQ,
      BK_CHK,
      BK_ROOT,
      BK_THIT,
      BK_HIT,
      BK_FIN,
      BK_DIV,
      BK_EMIT
   } bk_state_type;

endpackage
`default_nettype wire

>>> rtl/core/nrch_front.sv
// Front part: takes input beats, classifies each object and queues it.
// Depends on nrch_pkg.
`default_nettype none
module nrch_front #(
   parameter int unsigned OBJECT_ID_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output logic                             in_stall,
   input  wire logic [19:0]                 origin_x,
   input  wire logic [19:0]                 origin_y,
   input  wire logic signed [15:0]          dir_x,
   input  wire logic signed [15:0]          dir_y,
   input  wire logic [19:0]                 obj_x,
   input  wire logic [19:0]                 obj_y,
   input  wire logic [15:0]                 obj_radius,
   input  wire logic                        obj_active,
   input  wire logic [15:0]                 obj_id,
   input  wire logic [15:0]                 skip_id,
   input  wire logic                        last_object,
   output logic                             q_valid,
   output nrch_pkg::q_item_type             q_item,
   input  wire logic                        q_pop
);
   import nrch_pkg::*;

   localparam int unsigned CmpBits = (OBJECT_ID_BITS < IdWidth) ? OBJECT_ID_BITS : IdWidth;

   q_item_type  entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   logic        excluded;
   q_item_type  new_item;

   assign excluded = (obj_id[CmpBits-1:0] == skip_id[CmpBits-1:0]);
   assign in_stall = (count_ff == 2'd2);
   assign push     = in_valid && !in_stall;
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = entry_ff[rd_ptr_ff];

   always_comb begin
      new_item.dx      = delta_type'({1'b0, obj_x}) - delta_type'({1'b0, origin_x});
      new_item.dy      = delta_type'({1'b0, obj_y}) - delta_type'({1'b0, origin_y});
      new_item.ux      = dir_x;
      new_item.uy      = dir_y;
      new_item.rad     = obj_radius;
      new_item.use_obj = obj_active && !excluded;
      new_item.last    = last_object;
   end

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/nrch_back.sv
// Back part: sequencer that tests one queued object against the ray,
// keeps the running nearest hit and produces the result beat.
// Depends on nrch_pkg.
`default_nettype none
module nrch_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [15:0]          max_range,
   input  wire logic                 q_valid,
   input  nrch_pkg::q_item_type      q_item,
   output logic                      q_pop,
   output logic                      out_valid,
   input  wire logic                 out_stall,
   output logic [15:0]               out_range_q,
   output logic                      out_hit,
   output logic [15:0]               out_close
);
   import nrch_pkg::*;

   bk_state_type        state_ff, state_in;
   q_item_type          item_ff;
   logic [41:0]         dxsq_ff, dysq_ff;
   logic [31:0]         lsq_ff;
   logic signed [36:0]  m0_ff, m1_ff, m2_ff, m3_ff;
   logic [23:0]         tq_ff, pq_ff;
   logic [47:0]         p2_ff;
   logic [31:0]         r2_ff;
   logic [31:0]         v_ff;
   logic [32:0]         res_ff;
   logic [31:0]         bit_ff;
   logic [3:0]          cnt_ff;
   logic [15:0]         h_ff;
   logic [15:0]         run_ff;
   logic [16:0]         rem_ff;
   logic [15:0]         quot_ff;
   logic [15:0]         fin_dist_ff;
   logic                fin_hit_ff;
   logic                out_valid_ff;
   logic [15:0]         dist_ff, close_ff;
   logic                hit_ff;

   logic [42:0]         d2;
   logic                out_range;
   logic signed [37:0]  t_sum, p_sum, p_abs;
   logic                miss_r;
   logic [32:0]         root_try;
   logic                root_take;
   logic signed [25:0]  tq_s, t_near, t_hit;
   logic                hit_ok;
   logic [17:0]         rem_sh;
   logic                div_take;
   logic                rsp_load;
   logic                rsp_take;

   // Datapath helpers.
   always_comb begin
      d2        = {1'b0, dxsq_ff} + {1'b0, dysq_ff};
      out_range = d2 > {11'b0, lsq_ff};
      t_sum     = {m0_ff[36], m0_ff} + {m1_ff[36], m1_ff};
      p_sum     = {m2_ff[36], m2_ff} - {m3_ff[36], m3_ff};
      p_abs     = p_sum[37] ? -p_sum : p_sum;
      miss_r    = p2_ff > {16'b0, r2_ff};
      root_try  = res_ff + {1'b0, bit_ff};
      root_take = {1'b0, v_ff} >= root_try;
      tq_s      = {2'b00, tq_ff};
      t_near    = tq_s - {10'b0, res_ff[15:0]};
      t_hit     = t_near[25] ? tq_s + {10'b0, res_ff[15:0]} : t_near;
      hit_ok    = !t_hit[25] && (t_hit != 26'sd0) && (t_hit < {10'b0, max_range});
      rem_sh    = {rem_ff, 1'b0};
      div_take  = rem_sh >= {2'b00, max_range};
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               if (q_item.use_obj) begin
                  state_in = BK_SQR;
               end else if (q_item.last) begin
                  state_in = BK_FIN;
               end
            end
         end
         BK_SQR:   state_in = BK_RANGE;
         BK_RANGE: state_in = out_range ? BK_HIT : BK_PROJ;
         BK_PROJ:  state_in = BK_SUM;
         BK_SUM:   state_in = t_sum[37] ? BK_HIT : BK_PSQ;
         BK_PSQ:   state_in = BK_CHK;
         BK_CHK:   state_in = miss_r ? BK_HIT : BK_ROOT;
         BK_ROOT:  state_in = (cnt_ff == 4'd15) ? BK_THIT : BK_ROOT;
         BK_THIT:  state_in = BK_HIT;
         BK_HIT:   state_in = item_ff.last ? BK_FIN : BK_IDLE;
         BK_FIN:   state_in = (run_ff >= max_range) ? BK_EMIT : BK_DIV;
         BK_DIV:   state_in = (cnt_ff == 4'd15) ? BK_EMIT : BK_DIV;
         BK_EMIT:  state_in = rsp_load ? BK_IDLE : BK_EMIT;
         default:  state_in = BK_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      q_pop    = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         BK_IDLE: q_pop    = q_valid;
         BK_EMIT: rsp_load = !out_valid_ff || !out_stall;
         default: begin
            q_pop    = 1'b0;
            rsp_load = 1'b0;
         end
      endcase
   end

   assign rsp_take    = out_valid_ff && !out_stall;
   assign out_valid   = out_valid_ff;
   assign out_range_q = dist_ff;
   assign out_hit     = hit_ff;
   assign out_close   = close_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         run_ff       <= RayLengthRst;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_HIT && h_ff < run_ff) begin
            run_ff <= h_ff;
         end else if (rsp_load) begin
            run_ff <= max_range;
         end
         if (rsp_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         BK_IDLE: begin
            item_ff <= q_item;
         end
         BK_SQR: begin
            dxsq_ff <= 42'(item_ff.dx * item_ff.dx);
            dysq_ff <= 42'(item_ff.dy * item_ff.dy);
            lsq_ff  <= max_range * max_range;
         end
         BK_RANGE: begin
            h_ff <= max_range;
         end
         BK_PROJ: begin
            m0_ff <= item_ff.dx * item_ff.ux;
            m1_ff <= item_ff.dy * item_ff.uy;
            m2_ff <= item_ff.dx * item_ff.uy;
            m3_ff <= item_ff.dy * item_ff.ux;
         end
         BK_SUM: begin
            tq_ff <= t_sum[37:14];
            pq_ff <= p_abs[37:14];
         end
         BK_PSQ: begin
            p2_ff <= pq_ff * pq_ff;
            r2_ff <= item_ff.rad * item_ff.rad;
         end
         BK_CHK: begin
            v_ff   <= r2_ff - p2_ff[31:0];
            res_ff <= 33'd0;
            bit_ff <= 32'h4000_0000;
            cnt_ff <= 4'd0;
         end
         BK_ROOT: begin
            if (root_take) begin
               v_ff   <= v_ff - root_try[31:0];
               res_ff <= (res_ff >> 1) + {1'b0, bit_ff};
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            cnt_ff <= cnt_ff + 4'd1;
         end
         BK_THIT: begin
            h_ff <= hit_ok ? t_hit[15:0] : max_range;
         end
         BK_FIN: begin
            // The result is staged here; the output register may still hold
            // the previous beat.
            if (run_ff >= max_range) begin
               fin_dist_ff <= max_range;
               fin_hit_ff  <= 1'b0;
            end else begin
               fin_dist_ff <= run_ff;
               fin_hit_ff  <= 1'b1;
               rem_ff      <= {1'b0, max_range - run_ff};
               quot_ff     <= 16'd0;
               cnt_ff      <= 4'd0;
            end
         end
         BK_DIV: begin
            if (div_take) begin
               rem_ff  <= 17'(rem_sh - {2'b00, max_range});
               quot_ff <= {quot_ff[14:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh[16:0];
               quot_ff <= {quot_ff[14:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 4'd1;
         end
         BK_EMIT: begin
            if (rsp_load) begin
               dist_ff  <= fin_dist_ff;
               hit_ff   <= fin_hit_ff;
               close_ff <= fin_hit_ff ? quot_ff : 16'd0;
            end
         end
         default: begin
            h_ff <= h_ff;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> rtl/core/nearest_ray_circle_hit.sv
// Nearest ray/circle hit: every beat is registered in the queue; the back part then
// passes over a skipped object in its idle state and tests any other one, which can
// take a 16-step square-root loop. A last object then adds the 16-step closeness
// divider on a hit and the emit state, which waits for the output register to be free.
// The single back-end sequencer finishes one object before it takes the next.
// Reset (synchronous, active high) empties the queue, drops any pending result and
// sets the maximum range to 100 pixels and the running nearest hit to that range.
`default_nettype none
module nearest_ray_circle_hit #(
   parameter int unsigned OBJECT_ID_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // Input channel: one beat per circle, tested against the ray it carries.
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [19:0]         req_origin_x,
   input  wire logic [19:0]         req_origin_y,
   input  wire logic signed [15:0]  req_dir_x,
   input  wire logic signed [15:0]  req_dir_y,
   input  wire logic [19:0]         req_obj_x,
   input  wire logic [19:0]         req_obj_y,
   input  wire logic [15:0]         req_obj_radius,
   input  wire logic                req_obj_active,
   input  wire logic [15:0]         req_obj_id,
   input  wire logic [15:0]         req_skip_id,
   input  wire logic                req_last_object,
   // Result channel: one beat for each last object.
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [15:0]              rsp_near_range,
   output logic                     rsp_hit,
   output logic [15:0]              rsp_closeness,
   // Register port.
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [2:0]          paddr,
   input  wire logic [31:0]         pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);
   import nrch_pkg::*;

   logic [15:0]  max_range_ff;
   logic         q_valid;
   q_item_type   q_item;
   logic         q_pop;

   // The only register, the maximum range, sits at byte address zero. Writes
   // to any other word are dropped.
   assign pready = 1'b1;
   assign prdata = (paddr[2:2] == RegRayLength) ? {16'b0, max_range_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_range_ff <= RayLengthRst;
      end else if (psel && penable && pwrite && paddr[2:2] == RegRayLength) begin
         max_range_ff <= pwdata[15:0];
      end
   end

   // The front part computes the offsets to the circle center and decides
   // whether the object takes part at all; its two-entry queue lets it keep
   // accepting beats while the back part is busy.
   nrch_front #(
      .OBJECT_ID_BITS (OBJECT_ID_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_stall    (req_stall),
      .origin_x    (req_origin_x),
      .origin_y    (req_origin_y),
      .dir_x       (req_dir_x),
      .dir_y       (req_dir_y),
      .obj_x       (req_obj_x),
      .obj_y       (req_obj_y),
      .obj_radius  (req_obj_radius),
      .obj_active  (req_obj_active),
      .obj_id      (req_obj_id),
      .skip_id     (req_skip_id),
      .last_object (req_last_object),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop)
   );

   // The back part runs the range test, projection, square root and the
   // closeness division, then holds the result in an output register so a
   // stalled result does not block the next object.
   nrch_back u_back (
      .clock       (clock),
      .reset       (reset),
      .max_range   (max_range_ff),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .out_range_q (rsp_near_range),
      .out_hit     (rsp_hit),
      .out_close   (rsp_closeness)
   );

endmodule
`default_nettype wire

>>> rtl/core/nrch_checker.sv
// Port-level checks for nearest_ray_circle_hit, attached by bind.
// Depends only on the top level's ports.
`default_nettype none
module nrch_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         rsp_valid,
   input  wire logic         rsp_stall,
   input  wire logic [15:0]  rsp_near_range,
   input  wire logic         rsp_hit,
   input  wire logic [15:0]  rsp_closeness,
   input  wire logic [31:0]  prdata,
   input  wire logic [2:0]   paddr
);

   // A stalled result beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_near_range)
         && $stable(rsp_hit) && $stable(rsp_closeness))
      else $error("result beat changed while stalled");

   // A miss reports zero closeness.
   a_miss_close: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_closeness == 16'd0)
      else $error("miss with nonzero closeness");

   // A hit lies strictly inside the configured range; checked while paddr is zero.
   a_hit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit && paddr == 3'd0 |-> rsp_near_range < prdata[15:0])
      else $error("hit at or beyond the maximum range");

   // No result right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind nearest_ray_circle_hit nrch_checker u_nrch_checker (.*);
`default_nettype wire

>>> sim/nearest_ray_circle_hit_tb.sv
// Self-checking testbench for nearest_ray_circle_hit: circle beats are driven against
// random rays, a local predictor computes the nearest-hit result for each last object.
// Depends on the block's RTL only (nrch_pkg for the register address and reset range).
`timescale 1ns / 1ps
module nearest_ray_circle_hit_tb;
   import nrch_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   // Input channel drive.
   logic req_valid = 1'b0;
   logic req_stall;
   logic [19:0] req_origin_x = '0, req_origin_y = '0, req_obj_x = '0, req_obj_y = '0;
   logic signed [15:0] req_dir_x = '0, req_dir_y = '0;
   logic [15:0] req_obj_radius = '0, req_obj_id = '0, req_skip_id = '0;
   logic req_obj_active = 1'b0, req_last_object = 1'b0;
   // Result channel.
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [15:0] rsp_near_range, rsp_closeness;
   logic rsp_hit;
   // Register port.
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   nearest_ray_circle_hit dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_origin_x, .req_origin_y, .req_dir_x, .req_dir_y,
      .req_obj_x, .req_obj_y, .req_obj_radius, .req_obj_active, .req_obj_id,
      .req_skip_id, .req_last_object,
      .rsp_valid, .rsp_stall, .rsp_near_range, .rsp_hit, .rsp_closeness,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   typedef struct packed {
      logic [15:0] hit_range;
      logic        hit;
      logic [15:0] close;
   } ray_result_type;

   typedef struct {
      logic [19:0] ox, oy, cx, cy;
      logic signed [15:0] ux, uy;
      logic [15:0] rad, id, excl;
      logic active, last;
   } circle_beat_type;

   // Predictor state mirrors the block: current range and nearest hit of the open ray.
   logic [15:0] pred_max_range = RayLengthRst;
   logic [15:0] pred_nearest = RayLengthRst;
   ray_result_type expected_results[$];

   int errors = 0;
   int unsigned cycle_count = 0;
   int unsigned send_idle_pct = 0, recv_idle_pct = 0;
   int unsigned hold_off_cycles = 0;

   localparam int unsigned CycleLimit = 2_000_000;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // Hit distance of one circle in Q8.8, or the range limit when the ray misses it.
   function automatic longint unsigned circle_distance(circle_beat_type b,
                                                       longint unsigned len);
      longint dx, dy, ux, uy, t, p, tq, pq, thit;
      longint unsigned d2, r2, p2, half;
      dx = longint'(b.cx) - longint'(b.ox);
      dy = longint'(b.cy) - longint'(b.oy);
      ux = b.ux;
      uy = b.uy;
      d2 = longint'(dx * dx) + longint'(dy * dy);
      if (d2 > len * len) return len;
      t = dx * ux + dy * uy;
      if (t < 0) return len;
      p = dx * uy - dy * ux;
      if (p < 0) p = -p;
      tq = t >>> 14;
      pq = p >>> 14;
      p2 = pq * pq;
      r2 = longint'(b.rad) * longint'(b.rad);
      if (p2 > r2) return len;
      half = int_sqrt(r2 - p2);
      thit = tq - longint'(half);
      if (thit < 0) thit = tq + longint'(half);
      if (thit > 0 && longint'(thit) < longint'(len)) return thit;
      return len;
   endfunction

   function automatic void predict_beat(circle_beat_type b);
      longint unsigned h, len, best, cl;
      ray_result_type r;
      len = pred_max_range;
      if (b.active && b.id != b.excl) begin
         h = circle_distance(b, len);
         if (h < pred_nearest) pred_nearest = h[15:0];
      end
      if (b.last) begin
         best = pred_nearest;
         if (best >= len) begin
            r = '{hit_range: len[15:0], hit: 1'b0, close: 16'd0};
         end else begin
            cl = ((len - best) << 16) / len;
            if (cl > 65535) cl = 65535;
            r = '{hit_range: best[15:0], hit: 1'b1, close: cl[15:0]};
         end
         expected_results.push_back(r);
         pred_nearest = pred_max_range;
      end
   endfunction

   // Timeout watchdog and cycle counter.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("nearest_ray_circle_hit verification failed");
         $finish;
      end
   end

   // Receiver: random stall, plus long hold-off stretches requested by a test.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_cycles != 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Result checker: every accepted beat is compared with the oldest expectation.
   always @(posedge clock) begin
      ray_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result range=%0d hit=%0d close=%0d", $time,
                     rsp_near_range, rsp_hit, rsp_closeness);
            errors++;
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_near_range !== exp_r.hit_range) begin
               $display("%0t: near_range expected %0d actual %0d", $time,
                        exp_r.hit_range, rsp_near_range);
               errors++;
            end
            if (rsp_hit !== exp_r.hit) begin
               $display("%0t: hit expected %0d actual %0d", $time, exp_r.hit, rsp_hit);
               errors++;
            end
            if (rsp_closeness !== exp_r.close) begin
               $display("%0t: closeness expected %0d actual %0d", $time, exp_r.close,
                        rsp_closeness);
               errors++;
            end
         end
      end
   end

   // Sends one beat; valid stays high across back-to-back beats.
   task automatic send_beat(circle_beat_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_origin_x    <= b.ox;
      req_origin_y    <= b.oy;
      req_dir_x       <= b.ux;
      req_dir_y       <= b.uy;
      req_obj_x       <= b.cx;
      req_obj_y       <= b.cy;
      req_obj_radius  <= b.rad;
      req_obj_active  <= b.active;
      req_obj_id      <= b.id;
      req_skip_id     <= b.excl;
      req_last_object <= b.last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_beat(b);
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      // Non-last objects yield no result, so let the back end drain completely.
      repeat (100) @(posedge clock);
   endtask

   // Register write; the block must be idle. The open ray's nearest hit is kept.
   task automatic write_max_range(logic [15:0] len);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {RegRayLength, 2'b00};
      pwdata  <= {16'd0, len};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      pred_max_range = len;
   endtask

   // Random unit direction in Q1.14, with the axis extremes now and then.
   function automatic void random_dir(output logic signed [15:0] ux,
                                      output logic signed [15:0] uy);
      real a;
      case ($urandom_range(7))
         0: begin ux = 16'sd16384;  uy = 16'sd0;      end
         1: begin ux = -16'sd16384; uy = 16'sd0;      end
         2: begin ux = 16'sd0;      uy = 16'sd16384;  end
         3: begin ux = 16'sd0;      uy = -16'sd16384; end
         default: begin
            a  = $urandom_range(62831) / 10000.0;
            ux = 16'($rtoi($cos(a) * 16384.0));
            uy = 16'($rtoi($sin(a) * 16384.0));
         end
      endcase
   endfunction

   // A circle placed near the ray so that most beats reach the root and hit logic.
   function automatic circle_beat_type random_circle(logic [19:0] ox, logic [19:0] oy,
                                                     logic signed [15:0] ux,
                                                     logic signed [15:0] uy,
                                                     logic [15:0] excl, logic last);
      circle_beat_type b;
      int along, side;
      b.ox = ox; b.oy = oy; b.ux = ux; b.uy = uy; b.excl = excl; b.last = last;
      if ($urandom_range(9) == 0) begin
         // Noise: anywhere in the plane, any radius, any direction.
         b.cx  = 20'($urandom);
         b.cy  = 20'($urandom);
         b.rad = 16'($urandom);
      end else begin
         along = int'($urandom_range(pred_max_range + 2000)) - 1000;
         side  = int'($urandom_range(6000)) - 3000;
         b.cx  = 20'(int'(ox) + ((along * ux - side * uy) >>> 14));
         b.cy  = 20'(int'(oy) + ((along * uy + side * ux) >>> 14));
         b.rad = 16'($urandom_range(4000));
      end
      b.active = ($urandom_range(9) != 0);
      b.id     = ($urandom_range(9) == 0) ? excl : 16'($urandom);
      return b;
   endfunction

   task automatic send_random_rays(int unsigned n_items);
      logic [19:0] ox, oy;
      logic signed [15:0] ux, uy;
      logic [15:0] excl;
      int unsigned count, left;
      count = 0;
      while (count < n_items) begin
         ox = 20'($urandom_range(1040000, 8000));
         oy = 20'($urandom_range(1040000, 8000));
         if ($urandom_range(19) == 0) begin
            ox = 20'($urandom); oy = 20'($urandom);
         end
         random_dir(ux, uy);
         if ($urandom_range(19) == 0) begin
            ux = 16'($urandom); uy = 16'($urandom);   // non-unit direction
         end
         excl = 16'($urandom);
         left = $urandom_range(6, 1);
         for (int unsigned i = 0; i < left; i++) begin
            send_beat(random_circle(ox, oy, ux, uy, excl, i == left - 1));
            count++;
         end
      end
   endtask

   task automatic test_directed();
      circle_beat_type b;
      b = '{ox: 20'd100000, oy: 20'd100000, cx: 20'd110000, cy: 20'd100000,
            ux: 16'sd16384, uy: 16'sd0, rad: 16'd1000, id: 16'd5, excl: 16'd7,
            active: 1'b1, last: 1'b1};
      send_beat(b);                                     // plain hit ahead
      b.cx = 20'd90000;  send_beat(b);                  // circle behind origin
      b.cx = 20'd100000; send_beat(b);                  // origin inside: far root
      b.cx = 20'd100000 + 20'd25600; b.rad = 16'd0; send_beat(b);  // touching range
      b.cx = 20'd110000; b.cy = 20'd102000; b.rad = 16'd1000; send_beat(b); // side miss
      b.cy = 20'd100000; b.id = 16'd7; send_beat(b);    // excluded id
      b.id = 16'd5; b.active = 1'b0; send_beat(b);      // inactive
      b.active = 1'b1; b.cx = 20'd200000; send_beat(b); // beyond the range
      b.ux = 16'sh7fff; b.uy = 16'sh8000; b.cx = 20'd110000; send_beat(b); // non-unit
      b.ux = -16'sd16384; b.uy = 16'sd0; b.cx = 20'd90000; send_beat(b);
      b.ux = 16'sd0; b.uy = 16'sd16384; b.cx = 20'd100000; b.cy = 20'd100256;
      b.rad = 16'd256; send_beat(b);                    // distance one near zero
      b = '{ox: 20'hFFFFF, oy: 20'hFFFFF, cx: 20'd0, cy: 20'd0, ux: -16'sd16384,
            uy: 16'sd0, rad: 16'hFFFF, id: 16'hFFFF, excl: 16'h0000, active: 1'b1,
            last: 1'b1};
      send_beat(b);                                     // field extremes
      b.ox = '0; b.oy = '0; b.cx = 20'hFFFFF; b.cy = 20'hFFFFF; b.ux = 16'sd16384;
      send_beat(b);
      // Several objects in one ray, nearest in the middle.
      b = '{ox: 20'd50000, oy: 20'd50000, cx: 20'd60000, cy: 20'd50000, ux: 16'sd16384,
            uy: 16'sd0, rad: 16'd500, id: 16'd1, excl: 16'd9, active: 1'b1, last: 1'b0};
      send_beat(b);
      b.cx = 20'd54000; send_beat(b);
      b.cx = 20'd70000; b.last = 1'b1; send_beat(b);
      go_idle();
   endtask

   task automatic test_range_settings();
      logic [15:0] lens[4] = '{16'd256, 16'd65535, 16'd0, 16'd3000};
      foreach (lens[i]) begin
         write_max_range(lens[i]);
         send_random_rays(20);
         go_idle();
      end
      write_max_range(RayLengthRst);
   endtask

   task automatic test_random_traffic();
      send_idle_pct = 37; recv_idle_pct = 84;
      send_random_rays(90);
      go_idle();
      write_max_range(16'($urandom_range(65535, 256)));
      send_idle_pct = 84; recv_idle_pct = 37;
      send_random_rays(90);
      go_idle();
      write_max_range(RayLengthRst);
      send_idle_pct = 0; recv_idle_pct = 0;
      send_random_rays(90);
      go_idle();
   endtask

   task automatic test_back_pressure();
      send_idle_pct = 0; recv_idle_pct = 0;
      @(posedge clock);
      hold_off_cycles <= 3000;
      send_random_rays(40);
      go_idle();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_range_settings();
      test_back_pressure();
      test_random_traffic();
      if (errors == 0 && expected_results.size() == 0) begin
         $display("nearest_ray_circle_hit verification clean");
      end else begin
         $display("nearest_ray_circle_hit verification failed");
      end
      $finish;
   end
endmodule
